/* rtl/core/gbop_pkg.sv */
`timescale 1ns / 1ps
package gbop_pkg;

    localparam int MAX_ASSETS = 8;
    localparam int NA_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_W      = 36;
    localparam int DIV_STEPS  = 6;
    localparam int DIV_STAGES = DIV_W / DIV_STEPS;
    // sum, divider stages, three exp stages, payoff register
    localparam int NUM_STAGES = 1 + DIV_STAGES + 3 + 1;

    localparam logic [CFG_IDX_W-1:0] REG_STRIKE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUT        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ASSETS = 2'd2;

    localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;

    // 2^(i/16) in Q2.24
    function automatic logic [25:0] exp2_tab(input logic [4:0] idx);
        logic [25:0] t;
        unique case (idx)
            5'd0:  t = 26'd16777216;
            5'd1:  t = 26'd17520007;
            5'd2:  t = 26'd18295684;
            5'd3:  t = 26'd19105703;
            5'd4:  t = 26'd19951585;
            5'd5:  t = 26'd20834917;
            5'd6:  t = 26'd21757357;
            5'd7:  t = 26'd22720638;
            5'd8:  t = 26'd23726566;
            5'd9:  t = 26'd24777031;
            5'd10: t = 26'd25874004;
            5'd11: t = 26'd27019544;
            5'd12: t = 26'd28215802;
            5'd13: t = 26'd29465022;
            5'd14: t = 26'd30769550;
            5'd15: t = 26'd32131834;
            default: t = 26'd33554432;
        endcase
        return t;
    endfunction

endpackage

/* rtl/core/gbop_if.sv */
`timescale 1ns / 1ps
interface gbop_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] log_price_0;
    logic signed [31:0] log_price_1;
    logic signed [31:0] log_price_2;
    logic signed [31:0] log_price_3;
    logic signed [31:0] log_price_4;
    logic signed [31:0] log_price_5;
    logic signed [31:0] log_price_6;
    logic signed [31:0] log_price_7;
    logic [15:0]        time_step;
    logic [15:0]        node;

    modport source (output valid, log_price_0, log_price_1, log_price_2, log_price_3,
                    log_price_4, log_price_5, log_price_6, log_price_7, time_step, node,
                    input ready);
    modport sink (input valid, log_price_0, log_price_1, log_price_2, log_price_3,
                  log_price_4, log_price_5, log_price_6, log_price_7, time_step, node,
                  output ready);
endinterface

interface gbop_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] payoff;
    logic [31:0] geo_mean;
    logic        saturated;
    logic [15:0] time_step_out;
    logic [15:0] node_out;

    modport source (output valid, payoff, geo_mean, saturated, time_step_out, node_out,
                    input ready);
    modport sink (input valid, payoff, geo_mean, saturated, time_step_out, node_out,
                  output ready);
endinterface

/* rtl/core/gbop_sum.sv */
`timescale 1ns / 1ps
module gbop_sum
    import gbop_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [NA_W-1:0]         n,
    input  logic signed [31:0]      lanes [MAX_ASSETS],
    output logic [DIV_W-1:0]        dividend_reg
);

    logic signed [DIV_W-1:0] sum;
    logic [DIV_W-1:0]        dividend_next;

    // offset by n * 2^32 so the dividend is never negative; floor division then
    // reduces to plain unsigned division
    always_comb
    begin
        sum = '0;
        for (int l = 0; l < MAX_ASSETS; l++)
        begin
            if (l < int'(n))
                sum = sum + DIV_W'(lanes[l]);
        end
        dividend_next = DIV_W'(sum) + {n, 32'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dividend_reg <= dividend_next;
    end

endmodule

/* rtl/core/gbop_div_stage.sv */
`timescale 1ns / 1ps
module gbop_div_stage
    import gbop_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NA_W-1:0]  n,
    input  logic [DIV_W-1:0] dq_in,
    input  logic [2:0]       rem_in,
    output logic [DIV_W-1:0] dq_reg,
    output logic [2:0]       rem_reg
);

    logic [DIV_W-1:0] dq_next;
    logic [2:0]       rem_next;
    logic [3:0]       t;

    // restoring division, dividend bits shift out the top, quotient bits in the bottom
    always_comb
    begin
        dq_next  = dq_in;
        rem_next = rem_in;
        t        = '0;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            t = {rem_next, dq_next[DIV_W-1]};
            if (t >= n)
            begin
                t       = t - n;
                dq_next = {dq_next[DIV_W-2:0], 1'b1};
            end
            else
            begin
                dq_next = {dq_next[DIV_W-2:0], 1'b0};
            end
            rem_next = t[2:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

endmodule

/* rtl/core/gbop_exp.sv */
`timescale 1ns / 1ps
module gbop_exp
    import gbop_pkg::*;
(
    input  logic               clk,
    input  logic [2:0]         en,
    input  logic signed [31:0] mean,
    output logic [31:0]        geo_reg,
    output logic               sat_reg
);

    // stage A: scale to log2
    logic signed [63:0] p;
    logic signed [8:0]  ka_reg;
    logic [3:0]         idx_reg;
    logic [19:0]        fr_reg;

    assign p = mean * LOG2E_Q30;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ka_reg  <= p[62:54];
            idx_reg <= p[53:50];
            fr_reg  <= p[49:30];
        end
    end

    // stage B: table and interpolation product
    logic [25:0] t0;
    logic [25:0] t1;
    logic [20:0] diff;
    logic [40:0] prod;
    logic [25:0] t0_reg;
    logic [20:0] frac_reg;
    logic signed [8:0] kb_reg;

    always_comb
    begin
        t0   = exp2_tab({1'b0, idx_reg});
        t1   = exp2_tab(5'({1'b0, idx_reg}) + 5'd1);
        diff = 21'(t1 - t0);
        prod = diff * fr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            t0_reg   <= t0;
            frac_reg <= prod[40:20];
            kb_reg   <= ka_reg;
        end
    end

    // stage C: sum and scale by 2^k
    logic [25:0]       v;
    logic signed [9:0] sh;
    logic [31:0]       geo_next;
    logic              sat_next;

    always_comb
    begin
        v        = t0_reg + 26'(frac_reg);
        sh       = 10'sd8 - 10'(kb_reg);
        sat_next = 1'b0;
        if (kb_reg >= 9'sd16)
        begin
            sat_next = 1'b1;
            geo_next = '1;
        end
        else if (kb_reg >= 9'sd8)
        begin
            geo_next = 32'(v) << kb_reg[2:0];
        end
        else if (sh >= 10'sd26)
        begin
            geo_next = '0;
        end
        else
        begin
            geo_next = 32'(v >> sh[4:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            geo_reg <= geo_next;
            sat_reg <= sat_next;
        end
    end

endmodule

/* rtl/core/geometric_basket_option_payoff.sv */
`timescale 1ns / 1ps
// Geometric-average basket payoff. One node enters per cycle while req.ready is high;
// each passes one summing stage, six stages of a six-bit-per-stage divider for
// the mean over num_assets, three exponential stages (log2 scaling multiply, table
// interpolation multiply, power-of-two shift) and the payoff output register.
// A stall at the output backs up only as far as the first empty stage.
// strike, put_not_call and num_assets must be written while the pipeline is empty.
module geometric_basket_option_payoff
    import gbop_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]          cfg_data,
    gbop_in_if.sink              req,
    gbop_out_if.source           rsp
);

    logic [31:0]     strike_reg;
    logic            put_reg;
    logic [NA_W-1:0] num_assets_reg;
    logic [NA_W-1:0] n_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strike_reg     <= '0;
            put_reg        <= 1'b0;
            num_assets_reg <= NA_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_STRIKE:     strike_reg     <= cfg_data;
                REG_PUT:        put_reg        <= cfg_data[0];
                REG_NUM_ASSETS: num_assets_reg <= cfg_data[NA_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (num_assets_reg == '0)
            n_eff = NA_W'(1);
        else if (num_assets_reg > NA_W'(MAX_ASSETS))
            n_eff = NA_W'(MAX_ASSETS);
        else
            n_eff = num_assets_reg;
    end

    // pipeline control
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] adv;

    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || rsp.ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
            adv[i] = !valid_reg[i] || adv[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (adv[0])
                valid_reg[0] <= req.valid;
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (adv[i])
                    valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    assign req.ready = adv[0];

    // tags ride alongside
    logic [15:0] ts_reg   [NUM_STAGES];
    logic [15:0] node_reg [NUM_STAGES];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ts_reg[0]   <= req.time_step;
            node_reg[0] <= req.node;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (adv[i])
            begin
                ts_reg[i]   <= ts_reg[i-1];
                node_reg[i] <= node_reg[i-1];
            end
        end
    end

    logic signed [31:0] lanes [MAX_ASSETS];
    assign lanes[0] = req.log_price_0;
    assign lanes[1] = req.log_price_1;
    assign lanes[2] = req.log_price_2;
    assign lanes[3] = req.log_price_3;
    assign lanes[4] = req.log_price_4;
    assign lanes[5] = req.log_price_5;
    assign lanes[6] = req.log_price_6;
    assign lanes[7] = req.log_price_7;

    logic [DIV_W-1:0] dq  [DIV_STAGES+1];
    logic [2:0]       rem [DIV_STAGES+1];

    assign rem[0] = '0;

    gbop_sum u_sum (
        .clk          (clk),
        .en           (adv[0]),
        .n            (n_eff),
        .lanes        (lanes),
        .dividend_reg (dq[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        gbop_div_stage u_div (
            .clk     (clk),
            .en      (adv[g+1]),
            .n       (n_eff),
            .dq_in   (dq[g]),
            .rem_in  (rem[g]),
            .dq_reg  (dq[g+1]),
            .rem_reg (rem[g+1])
        );
    end

    // quotient minus 2^32 is the low word read as signed
    logic signed [31:0] mean;
    logic [31:0]        geo;
    logic               sat;

    assign mean = dq[DIV_STAGES][31:0];

    gbop_exp u_exp (
        .clk     (clk),
        .en      (adv[DIV_STAGES+3:DIV_STAGES+1]),
        .mean    (mean),
        .geo_reg (geo),
        .sat_reg (sat)
    );

    logic [31:0] payoff_reg;
    logic [31:0] payoff_next;
    logic [31:0] geo_out_reg;
    logic        sat_out_reg;

    always_comb
    begin
        if (put_reg)
            payoff_next = (strike_reg > geo) ? strike_reg - geo : '0;
        else
            payoff_next = (geo > strike_reg) ? geo - strike_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv[NUM_STAGES-1])
        begin
            payoff_reg  <= payoff_next;
            geo_out_reg <= geo;
            sat_out_reg <= sat;
        end
    end

    assign rsp.valid         = valid_reg[NUM_STAGES-1];
    assign rsp.payoff        = payoff_reg;
    assign rsp.geo_mean      = geo_out_reg;
    assign rsp.saturated     = sat_out_reg;
    assign rsp.time_step_out = ts_reg[NUM_STAGES-1];
    assign rsp.node_out      = node_reg[NUM_STAGES-1];

endmodule

/* rtl/core/gbop_checker.sv */
`timescale 1ns / 1ps
module gbop_checker
    import gbop_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_payoff,
    input logic [31:0] out_geo_mean,
    input logic        out_saturated
);

    logic [4:0] inflight_reg;
    logic [4:0] inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_valid && in_ready)
            inflight_next = inflight_next + 5'd1;
        if (out_valid && out_ready)
            inflight_next = inflight_next - 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payoff))
        else $error("result dropped or changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == 5'd0 |-> !out_valid)
        else $error("result with no item in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 5'(NUM_STAGES))
        else $error("more items in flight than pipeline stages");

    a_sat_mean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_saturated |-> out_geo_mean == 32'hFFFF_FFFF)
        else $error("saturated flag without saturated mean");

endmodule

bind geometric_basket_option_payoff gbop_checker u_gbop_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (req.valid),
    .in_ready      (req.ready),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_payoff    (rsp.payoff),
    .out_geo_mean  (rsp.geo_mean),
    .out_saturated (rsp.saturated)
);
